// ----- rtl/alw_pkg.sv -----
// Shared types and constants for the antialiased line stepper.
// No dependencies; imported by alw_div, antialiased_line_stepper and tb.
package alw_pkg;

    // Command codes carried in the slave-side tuser bit
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Pixel intensity
    localparam int unsigned LEVEL_BITS = 8;
    localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = 8'd255;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SETUP = 3'b010,
        S_DIV   = 3'b100
    } t_state;

    // Divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- rtl/alw_div.sv -----
// Bit-serial restoring divider for the line gradient: (a << FB) / d, a <= d.
// One quotient bit per cycle, FB+1 quotient bits in all. Depends on alw_pkg.
module alw_div #(
    parameter int unsigned CB = 11,
    parameter int unsigned FB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [CB-1:0]        i_dividend,
    input  logic [CB-1:0]        i_divisor,
    output alw_pkg::t_div_stat   o_stat,
    output logic [FB:0]          o_quot
);
    import alw_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(FB + 2);
    localparam logic [CNT_BITS-1:0] STEPS = CNT_BITS'(FB + 1);

    logic [CB:0]         r_rem, n_rem;
    logic [CB-1:0]       r_dvs;
    logic [FB:0]         r_quot, n_quot;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;

    logic [CB+1:0]       diff;
    logic                qbit;
    logic [CB:0]         kept;

    // one trial subtraction per cycle
    assign diff = {1'b0, r_rem} - {2'b00, r_dvs};
    assign qbit = ~diff[CB+1];
    assign kept = qbit ? diff[CB:0] : r_rem;

    always_comb begin
        n_rem  = r_rem;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = {1'b0, i_dividend};
            n_quot = '0;
            n_cnt  = STEPS;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the shift cannot overflow
            n_rem  = {kept[CB-1:0], 1'b0};
            n_quot = {r_quot[FB-1:0], qbit};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

// ----- rtl/antialiased_line_stepper.sv -----
// Antialiased line stepper: one column of two weighted pixels per advance word.
// Advance: accepted every cycle while the output register is free or being
// drained; its column is registered into the output register, ready in the next cycle.
// Start: no word is taken during the setup state, the FRAC_BITS+1 divider steps and the
// load of the gradient; a zero-length line blocks only for the setup state.
// Synchronous active-low reset clears the sequencer, output valid and line state.
module antialiased_line_stepper #(
    parameter int unsigned COORD_BITS = 11,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // slave side: tdata = start_x, start_y, end_x, end_y (low to high)
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     i_s_tdata,
    // tuser = command
    input  logic                                  i_s_tuser,
    // master side: tdata = near_px, near_py, near_level, far_px, far_py, far_level
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [((4*COORD_BITS+18+7)/8)*8-1:0]  o_m_tdata,
    // tlast = last_column
    output logic                                  o_m_tlast
);
    import alw_pkg::*;

    localparam int unsigned CB       = COORD_BITS;
    localparam int unsigned FB       = FRAC_BITS;
    localparam int unsigned ACC_BITS = CB + FB;
    localparam int unsigned IN_W     = ((4*CB+7)/8)*8;
    localparam int unsigned OUT_W    = ((4*CB+18+7)/8)*8;
    localparam int unsigned PAY_W    = 4*CB + 2 + 2*LEVEL_BITS;

    // sequencer and line state
    t_state              r_state, n_state;
    logic [CB-1:0]       r_ax, r_ay, r_bx, r_by;
    logic [CB-1:0]       r_major_pos, n_major_pos;
    logic [CB-1:0]       r_major_end, n_major_end;
    logic [ACC_BITS-1:0] r_minor_accum, n_minor_accum;
    logic [FB+1:0]       r_slope, n_slope;
    logic                r_steep, n_steep;
    logic                r_dy_neg, n_dy_neg;
    logic                r_line_active, n_line_active;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [PAY_W-1:0]    r_out_data, n_out_data;
    logic                r_out_last, n_out_last;

    logic                in_fire, out_free, adv_fire;

    assign out_free   = ~r_out_valid | i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) & out_free;
    assign in_fire    = i_s_tvalid & o_s_tready;
    assign adv_fire   = in_fire & (i_s_tuser == CMD_ADVANCE) & r_line_active;

    // setup: steepness, axis swap and endpoint ordering
    logic signed [CB:0] sdx, sdy, odx, ody;
    logic [CB-1:0]      adx, ady;
    logic               steep;
    logic [CB-1:0]      p0, q0, p1, q1;
    logic               swap_ends;
    logic [CB-1:0]      maj0, min0, maj1, min1;

    assign sdx   = $signed({1'b0, r_bx}) - $signed({1'b0, r_ax});
    assign sdy   = $signed({1'b0, r_by}) - $signed({1'b0, r_ay});
    assign adx   = sdx[CB] ? CB'(-sdx) : sdx[CB-1:0];
    assign ady   = sdy[CB] ? CB'(-sdy) : sdy[CB-1:0];
    assign steep = ady > adx;

    assign p0 = steep ? r_ay : r_ax;
    assign q0 = steep ? r_ax : r_ay;
    assign p1 = steep ? r_by : r_bx;
    assign q1 = steep ? r_bx : r_by;
    assign swap_ends = p0 > p1;
    assign maj0 = swap_ends ? p1 : p0;
    assign min0 = swap_ends ? q1 : q0;
    assign maj1 = swap_ends ? p0 : p1;
    assign min1 = swap_ends ? q0 : q1;

    assign odx = $signed({1'b0, maj1}) - $signed({1'b0, maj0});
    assign ody = $signed({1'b0, min1}) - $signed({1'b0, min0});

    // serial gradient divider
    t_div_stat     div_stat;
    logic [FB:0]   div_quot;
    logic          div_start;
    logic [CB-1:0] div_num;

    assign div_start = (r_state == S_SETUP) & (odx != '0);
    assign div_num   = ody[CB] ? CB'(-ody) : ody[CB-1:0];

    alw_div #(
        .CB (CB),
        .FB (FB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (odx[CB-1:0]),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // column: floor, fraction and levels
    logic [CB-1:0]      fl;
    logic [FB-1:0]      frac;
    logic [FB+7:0]      prod;
    logic [7:0]         far_lvl, near_lvl;
    logic [CB:0]        fl_up, maj_w;
    logic               last;

    assign fl       = r_minor_accum[ACC_BITS-1:FB];
    assign frac     = r_minor_accum[FB-1:0];
    // frac * 255 as (frac << 8) - frac
    assign prod     = {frac, 8'h00} - {8'h00, frac};
    assign far_lvl  = prod[FB+7:FB];
    assign near_lvl = FULL_LEVEL - far_lvl;
    assign fl_up    = {1'b0, fl} + 1'b1;
    assign maj_w    = {1'b0, r_major_pos};
    assign last     = r_major_pos == r_major_end;

    always_comb begin
        n_state       = r_state;
        n_major_pos   = r_major_pos;
        n_major_end   = r_major_end;
        n_minor_accum = r_minor_accum;
        n_slope       = r_slope;
        n_steep       = r_steep;
        n_dy_neg      = r_dy_neg;
        n_line_active = r_line_active;
        n_out_valid   = r_out_valid & ~i_m_tready;
        n_out_data    = r_out_data;
        n_out_last    = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (in_fire && i_s_tuser == CMD_START) begin
                    n_state = S_SETUP;
                end
                if (adv_fire) begin
                    n_out_valid = 1'b1;
                    n_out_last  = last;
                    if (r_steep) begin
                        n_out_data = {far_lvl, maj_w, fl_up, near_lvl, r_major_pos, fl};
                    end else begin
                        n_out_data = {far_lvl, fl_up, maj_w, near_lvl, fl, r_major_pos};
                    end
                    if (last) begin
                        n_line_active = 1'b0;
                    end else begin
                        n_major_pos   = r_major_pos + 1'b1;
                        n_minor_accum = r_minor_accum
                                      + {{(ACC_BITS-FB-2){r_slope[FB+1]}}, r_slope};
                    end
                end
            end
            S_SETUP: begin
                n_steep       = steep;
                n_major_pos   = maj0;
                n_major_end   = maj1;
                n_minor_accum = {min0, {FB{1'b0}}};
                n_dy_neg      = ody[CB];
                n_line_active = 1'b1;
                if (odx == '0) begin
                    n_slope = (FB+2)'(1) << FB;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_slope = r_dy_neg ? (FB+2)'(-{1'b0, div_quot})
                                       : {1'b0, div_quot};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_major_pos   <= '0;
            r_major_end   <= '0;
            r_minor_accum <= '0;
            r_slope       <= '0;
            r_steep       <= 1'b0;
            r_dy_neg      <= 1'b0;
            r_line_active <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_major_pos   <= n_major_pos;
            r_major_end   <= n_major_end;
            r_minor_accum <= n_minor_accum;
            r_slope       <= n_slope;
            r_steep       <= n_steep;
            r_dy_neg      <= n_dy_neg;
            r_line_active <= n_line_active;
            r_out_valid   <= n_out_valid;
        end
    end

    // endpoint latch and output payload, no reset
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        if (in_fire && i_s_tuser == CMD_START) begin
            r_ax <= i_s_tdata[CB-1:0];
            r_ay <= i_s_tdata[2*CB-1:CB];
            r_bx <= i_s_tdata[3*CB-1:2*CB];
            r_by <= i_s_tdata[4*CB-1:3*CB];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_data);
    assign o_m_tlast  = r_out_last;

    // the endpoint bits above the packed fields are padding
    logic unused_pad;
    assign unused_pad = ^(i_s_tdata >> (4*CB));

    // divider result only arrives while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    // an advance with no line in progress leaves nothing in the output register
    a_no_line_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_s_tuser == CMD_ADVANCE && !r_line_active) |=> !o_m_tvalid)
        else $error("word produced with no line in progress");

    // gradient magnitude never exceeds one once the line is running
    a_slope_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_line_active) |->
            ($signed(r_slope) <= $signed((FB+2)'(1) << FB) &&
             $signed(r_slope) >= -$signed((FB+2)'(1) << FB)))
        else $error("gradient out of range");

    // no word is taken while the gradient division is under way
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> !o_s_tready)
        else $error("input accepted during gradient division");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for antialiased_line_stepper (Wu line rasteriser).
// Needs only the RTL and alw_pkg; predicts each column word from the line words
// it accepts and checks every output word against that prediction.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alw_pkg::*;

    localparam int unsigned COORD_BITS = 11;
    localparam int unsigned FRAC_BITS  = 16;
    localparam int S_W = ((4*COORD_BITS+7)/8)*8;
    localparam int M_W = ((4*COORD_BITS+18+7)/8)*8;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int RANDOM_ITEMS = 1120;
    localparam int HOLD_CYCLES  = 220;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic                  cmd;
        logic [COORD_BITS-1:0] sx, sy, ex, ey;
    } t_line_word;

    typedef struct packed {
        logic [COORD_BITS-1:0] near_px;
        logic [COORD_BITS-1:0] near_py;
        logic [7:0]            near_lvl;
        logic [COORD_BITS:0]   far_px;
        logic [COORD_BITS:0]   far_py;
        logic [7:0]            far_lvl;
        logic                  last;
    } t_column;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic           i_s_tvalid = 1'b0;
    logic           o_s_tready;
    logic [S_W-1:0] i_s_tdata = '0;   // start_x, start_y, end_x, end_y, zero pad
    logic           i_s_tuser = CMD_START;  // command
    logic           o_m_tvalid;
    logic           i_m_tready = 1'b0;
    logic [M_W-1:0] o_m_tdata;  // near_px, near_py, near_level, far_px, far_py, far_level, pad
    logic           o_m_tlast;

    antialiased_line_stepper #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    // Stimulus and expectation stores
    t_line_word line_words[$];
    t_column    pending_columns[$];
    int total_words = 1;
    int stim_items = 0;

    // Shared run state
    int phase = 0;
    int words_taken = 0;
    int columns_seen = 0;
    int hold_left = 0;
    int holds_done = 0;
    int fault_cnt = 0;
    int lines_started = 0;
    int idle_advances = 0;
    int cycle_cnt = 0;

    // Predicted line state
    logic [COORD_BITS-1:0] ln_major = '0;
    logic [COORD_BITS-1:0] ln_end = '0;
    logic [63:0]           ln_minor = '0;
    longint                ln_slope = 0;
    logic                  ln_steep = 1'b0;
    logic                  ln_active = 1'b0;

    t_line_word drv_word;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Idle share per phase: sender 24/receiver 45, then swapped, then none
    function automatic int idle_share(input int ph, input bit is_sender);
        case (ph)
            0:       return is_sender ? 24 : 45;
            1:       return is_sender ? 45 : 24;
            default: return 0;
        endcase
    endfunction

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Wu stepper prediction for one accepted word
    task automatic rasterise_word(input logic cmd, input logic [COORD_BITS-1:0] sx,
                                  input logic [COORD_BITS-1:0] sy,
                                  input logic [COORD_BITS-1:0] ex,
                                  input logic [COORD_BITS-1:0] ey);
        int ax, ay, bx, by, t, dx, dy;
        longint mag;
        logic steep;
        logic [COORD_BITS-1:0] fl;
        logic [FRAC_BITS-1:0] frac;
        logic [7:0] far_lvl;
        t_column col;
        ax = int'(sx);
        ay = int'(sy);
        bx = int'(ex);
        by = int'(ey);
        if (cmd == CMD_START) begin
            steep = iabs(by - ay) > iabs(bx - ax);
            if (steep) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            dx = bx - ax;
            dy = by - ay;
            if (dx == 0) begin
                ln_slope = longint'(1) << FRAC_BITS;
            end else begin
                mag = (longint'(iabs(dy)) << FRAC_BITS) / dx;
                ln_slope = (dy < 0) ? -mag : mag;
            end
            ln_steep  = steep;
            ln_major  = ax[COORD_BITS-1:0];
            ln_end    = bx[COORD_BITS-1:0];
            ln_minor  = 64'(ay) << FRAC_BITS;
            ln_active = 1'b1;
            lines_started++;
        end else if (!ln_active) begin
            idle_advances++;
        end else begin
            fl      = ln_minor[FRAC_BITS +: COORD_BITS];
            frac    = ln_minor[FRAC_BITS-1:0];
            far_lvl = 8'((40'(frac) * 40'd255) >> FRAC_BITS);
            if (ln_steep) begin
                col.near_px = fl;
                col.near_py = ln_major;
                col.far_px  = {1'b0, fl} + 1'b1;
                col.far_py  = {1'b0, ln_major};
            end else begin
                col.near_px = ln_major;
                col.near_py = fl;
                col.far_px  = {1'b0, ln_major};
                col.far_py  = {1'b0, fl} + 1'b1;
            end
            col.near_lvl = 8'd255 - far_lvl;
            col.far_lvl  = far_lvl;
            col.last     = (ln_major == ln_end);
            pending_columns.push_back(col);
            if (col.last) begin
                ln_active = 1'b0;
            end else begin
                ln_major = ln_major + 1'b1;
                ln_minor = ln_minor + ln_slope;
            end
        end
    endtask

    // Compare one output word with the oldest prediction
    task automatic check_column();
        t_column got, want;
        logic bad;
        got.near_px  = o_m_tdata[10:0];
        got.near_py  = o_m_tdata[21:11];
        got.near_lvl = o_m_tdata[29:22];
        got.far_px   = o_m_tdata[41:30];
        got.far_py   = o_m_tdata[53:42];
        got.far_lvl  = o_m_tdata[61:54];
        got.last     = o_m_tlast;
        if (pending_columns.size() == 0) begin
            fault_cnt++;
            if (fault_cnt <= 10)
                $display("unexpected column word: near (%0d,%0d) far (%0d,%0d) last %0b",
                         got.near_px, got.near_py, got.far_px, got.far_py, got.last);
        end else begin
            want = pending_columns.pop_front();
            bad = (got.near_px !== want.near_px) || (got.near_py !== want.near_py) ||
                  (got.near_lvl !== want.near_lvl) || (got.far_px !== want.far_px) ||
                  (got.far_py !== want.far_py) || (got.far_lvl !== want.far_lvl) ||
                  (got.last !== want.last);
            if (bad) begin
                fault_cnt++;
                if (fault_cnt <= 10) begin
                    $display("column %0d mismatch", columns_seen);
                    $display("  exp near (%0d,%0d) lvl %0d far (%0d,%0d) lvl %0d last %0b",
                             want.near_px, want.near_py, want.near_lvl,
                             want.far_px, want.far_py, want.far_lvl, want.last);
                    $display("  got near (%0d,%0d) lvl %0d far (%0d,%0d) lvl %0d last %0b",
                             got.near_px, got.near_py, got.near_lvl,
                             got.far_px, got.far_py, got.far_lvl, got.last);
                end
            end
        end
    endtask

    task automatic queue_advances(input int n);
        t_line_word w;
        w.cmd = CMD_ADVANCE;
        w.sx = '0;
        w.sy = '0;
        w.ex = '0;
        w.ey = '0;
        repeat (n) begin
            w.sx = COORD_BITS'($urandom);
            w.sy = COORD_BITS'($urandom);
            w.ex = COORD_BITS'($urandom);
            w.ey = COORD_BITS'($urandom);
            line_words.push_back(w);
        end
    endtask

    // Start word then n advances; only words the block acts on are counted
    task automatic queue_line(input int ax, input int ay, input int bx, input int by,
                              input int n_adv);
        t_line_word w;
        int cols;
        w.cmd = CMD_START;
        w.sx = COORD_BITS'(ax);
        w.sy = COORD_BITS'(ay);
        w.ex = COORD_BITS'(bx);
        w.ey = COORD_BITS'(by);
        line_words.push_back(w);
        cols = ((iabs(bx - ax) > iabs(by - ay)) ? iabs(bx - ax) : iabs(by - ay)) + 1;
        stim_items += 1 + ((n_adv < cols) ? n_adv : cols);
        queue_advances(n_adv);
    endtask

    function automatic int near_coord(input int c, input int span);
        int lo, hi;
        lo = (c - span < 0) ? 0 : c - span;
        hi = (c + span > COORD_MAX) ? COORD_MAX : c + span;
        return $urandom_range(hi, lo);
    endfunction

    function automatic int columns_of(input int ax, input int ay, input int bx, input int by);
        return ((iabs(bx - ax) > iabs(by - ay)) ? iabs(bx - ax) : iabs(by - ay)) + 1;
    endfunction

    // Sender: offers queued words, holding each until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) begin
                words_taken <= words_taken + 1;
                phase <= ((words_taken + 1) * 3) / total_words;
            end
            if (line_words.size() != 0 && $urandom_range(99) >= idle_share(phase, 1'b1)) begin
                drv_word = line_words.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= drv_word.cmd;
                i_s_tdata  <= {{(S_W-4*COORD_BITS){1'b0}},
                               drv_word.ey, drv_word.ex, drv_word.sy, drv_word.sx};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus two long hold-offs to back the block up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (holds_done < 2 && columns_seen >= ((holds_done == 0) ? 250 : 700)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= idle_share(phase, 1'b0));
        end
    end

    // Monitor: predict on input words, check on output words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                rasterise_word(i_s_tuser, i_s_tdata[10:0], i_s_tdata[21:11],
                               i_s_tdata[32:22], i_s_tdata[43:33]);
            if (o_m_tvalid && i_m_tready) begin
                check_column();
                columns_seen <= columns_seen + 1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d columns outstanding",
                     cycle_cnt, pending_columns.size());
            $display("[antialiased_line_stepper] ERROR");
            $finish;
        end
    end

    initial begin
        int kind, ax, ay, bx, by, cols;

        // Directed: advance with no line, degenerate at the top corner,
        // reversed shallow, steep falling, far pixel at 2048, abandoned line
        queue_advances(1);
        queue_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 2);
        queue_line(5, 2, 0, 0, 6);
        queue_line(0, COORD_MAX, 2, COORD_MAX - 4, 5);
        queue_line(COORD_MAX - 1, 0, COORD_MAX, 3, 4);
        queue_line(0, 0, COORD_MAX, 1, 2);
        queue_line(1, 1, 3, 3, 3);

        // Random lines, mostly short and complete
        while (stim_items < RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            ax = $urandom_range(COORD_MAX);
            ay = $urandom_range(COORD_MAX);
            if (kind < 62) begin
                bx = near_coord(ax, $urandom_range(16));
                by = near_coord(ay, $urandom_range(16));
                cols = columns_of(ax, ay, bx, by);
                queue_line(ax, ay, bx, by, cols + (($urandom_range(9) == 0) ? 1 : 0));
            end else if (kind < 70) begin
                queue_line(ax, ay, ax, ay, 1);
            end else if (kind < 82) begin
                bx = near_coord(ax, $urandom_range(24, 4));
                by = near_coord(ay, $urandom_range(24, 4));
                cols = columns_of(ax, ay, bx, by);
                queue_line(ax, ay, bx, by, $urandom_range(cols - 1));
            end else if (kind < 92) begin
                queue_line(ax, ay, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                           $urandom_range(6));
            end else if (kind < 97) begin
                bx = near_coord(ax, 3);
                by = near_coord(ay, 3);
                queue_line(ax, ay, bx, by, columns_of(ax, ay, bx, by));
                queue_advances($urandom_range(4, 1));
            end else begin
                bx = near_coord(ax, $urandom_range(160, 48));
                by = near_coord(ay, $urandom_range(160, 48));
                queue_line(ax, ay, bx, by, columns_of(ax, ay, bx, by));
            end
        end
        total_words = line_words.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (line_words.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (pending_columns.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words sent: %0d lines, %0d columns checked, %0d idle advances",
                 words_taken, lines_started, columns_seen, idle_advances);
        $display("%0d receiver hold-offs, %0d failures", holds_done, fault_cnt);
        if (fault_cnt == 0 && pending_columns.size() == 0) begin
            $display("[antialiased_line_stepper] OK");
        end else begin
            $display("[antialiased_line_stepper] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/alw_pkg.sv
rtl/alw_div.sv
rtl/antialiased_line_stepper.sv
tb/tb.sv
